[rtl/t8pe_pkg.sv]
// shared types, codes and sizes of the toy 8-bit processor execute block
`timescale 1ns / 1ps

package t8pe_pkg;

  // storage sizes
  localparam int REG_COUNT   = 16;
  localparam int REG_AW      = $clog2(REG_COUNT);
  localparam int MEM_BYTES   = 256;
  localparam int MEM_AW      = $clog2(MEM_BYTES);
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);
  localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

  // command codes
  localparam logic [2:0] CMD_EXECUTE  = 3'd0;
  localparam logic [2:0] CMD_LOAD_REG = 3'd1;
  localparam logic [2:0] CMD_LOAD_MEM = 3'd2;
  localparam logic [2:0] CMD_READ_MEM = 3'd3;
  localparam logic [2:0] CMD_READ_REG = 3'd4;

  // opcodes
  localparam logic [3:0] OP_ADD    = 4'd0;
  localparam logic [3:0] OP_SUB    = 4'd1;
  localparam logic [3:0] OP_MUL    = 4'd2;
  localparam logic [3:0] OP_INC    = 4'd3;
  localparam logic [3:0] OP_AND    = 4'd4;
  localparam logic [3:0] OP_OR     = 4'd5;
  localparam logic [3:0] OP_NOT    = 4'd6;
  localparam logic [3:0] OP_XOR    = 4'd7;
  localparam logic [3:0] OP_LOAD   = 4'd8;
  localparam logic [3:0] OP_STORE  = 4'd9;
  localparam logic [3:0] OP_JUMP   = 4'd10;
  localparam logic [3:0] OP_BRANCH = 4'd11;
  localparam logic [3:0] OP_HALT   = 4'd15;

  // transaction class decided by the front end
  typedef enum logic [3:0] {
    K_ALU,
    K_LOAD,
    K_STORE,
    K_JUMP,
    K_BRANCH,
    K_NOP,
    K_HALT,
    K_LDREG,
    K_LDMEM,
    K_RDMEM,
    K_RDREG,
    K_IGNORE
  } t8pe_kind_t;

  // alu operation, same order as the low opcode bits
  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_INC,
    ALU_AND,
    ALU_OR,
    ALU_NOT,
    ALU_XOR
  } t8pe_alu_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RD0,
    BK_RD1,
    BK_EXEC,
    BK_MEM
  } t8pe_bk_state_t;

  // input transaction
  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] instr_word;
    logic [7:0]  target_index;
    logic [7:0]  load_value;
  } t8pe_in_t;

  // result transaction
  typedef struct packed {
    logic [7:0] next_pc;
    logic       halted;
    logic       wrote_register;
    logic [3:0] written_index;
    logic [7:0] written_value;
    logic [7:0] read_data;
  } t8pe_out_t;

  // classified item held in the queue
  typedef struct packed {
    t8pe_kind_t       kind;
    t8pe_alu_t        alu;
    logic [REG_AW-1:0] a_idx;
    logic [REG_AW-1:0] b_idx;
    logic [3:0]       c_fld;
    logic [7:0]       imm;
    logic [7:0]       tgt;
    logic [7:0]       val;
  } t8pe_item_t;

  // queue status seen by both ends
  typedef struct packed {
    logic empty;
    logic full;
  } t8pe_qstat_t;

endpackage

[rtl/t8pe_front.sv]
// front end: accepts transactions and classifies them for the back end
`timescale 1ns / 1ps

module t8pe_front (
  input  logic                  start,
  input  t8pe_pkg::t8pe_in_t    in_data,
  input  t8pe_pkg::t8pe_qstat_t q_stat,
  output logic                  busy,
  output logic                  push,
  output t8pe_pkg::t8pe_item_t  item
);

  logic [3:0] opcode;

  // accept whenever the queue has room
  assign busy   = q_stat.full;
  assign push   = start && !q_stat.full;
  assign opcode = in_data.instr_word[15:12];

  // classify command and opcode, split out the instruction fields
  always_comb begin
    item.alu   = t8pe_pkg::t8pe_alu_t'(opcode[2:0]);
    item.a_idx = in_data.instr_word[11:8];
    item.b_idx = in_data.instr_word[7:4];
    item.c_fld = in_data.instr_word[3:0];
    item.imm   = (opcode == t8pe_pkg::OP_JUMP) ? in_data.instr_word[11:4]
                                               : in_data.instr_word[7:0];
    item.tgt   = in_data.target_index;
    item.val   = in_data.load_value;
    case (in_data.cmd)
      t8pe_pkg::CMD_EXECUTE: begin
        case (opcode)
          t8pe_pkg::OP_ADD, t8pe_pkg::OP_SUB, t8pe_pkg::OP_MUL, t8pe_pkg::OP_INC,
          t8pe_pkg::OP_AND, t8pe_pkg::OP_OR, t8pe_pkg::OP_NOT,
          t8pe_pkg::OP_XOR:    item.kind = t8pe_pkg::K_ALU;
          t8pe_pkg::OP_LOAD:   item.kind = t8pe_pkg::K_LOAD;
          t8pe_pkg::OP_STORE:  item.kind = t8pe_pkg::K_STORE;
          t8pe_pkg::OP_JUMP:   item.kind = t8pe_pkg::K_JUMP;
          t8pe_pkg::OP_BRANCH: item.kind = t8pe_pkg::K_BRANCH;
          t8pe_pkg::OP_HALT:   item.kind = t8pe_pkg::K_HALT;
          default:             item.kind = t8pe_pkg::K_NOP;
        endcase
      end
      t8pe_pkg::CMD_LOAD_REG: item.kind = t8pe_pkg::K_LDREG;
      t8pe_pkg::CMD_LOAD_MEM: item.kind = t8pe_pkg::K_LDMEM;
      t8pe_pkg::CMD_READ_MEM: item.kind = t8pe_pkg::K_RDMEM;
      t8pe_pkg::CMD_READ_REG: item.kind = t8pe_pkg::K_RDREG;
      default:                item.kind = t8pe_pkg::K_IGNORE;
    endcase
  end

endmodule

[rtl/t8pe_queue.sv]
// short fifo of classified items between front and back end
`timescale 1ns / 1ps

module t8pe_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  t8pe_pkg::t8pe_item_t  push_item,
  input  logic                  pop,
  output t8pe_pkg::t8pe_item_t  head_item,
  output t8pe_pkg::t8pe_qstat_t q_stat
);

  t8pe_pkg::t8pe_item_t        q_r [t8pe_pkg::QUEUE_DEPTH];
  logic [t8pe_pkg::Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [t8pe_pkg::Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [t8pe_pkg::Q_CW-1:0]   cnt_r, cnt_nxt;

  assign head_item    = q_r[rd_ptr_r];
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == t8pe_pkg::Q_CW'(t8pe_pkg::QUEUE_DEPTH));

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == t8pe_pkg::Q_AW'(t8pe_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == t8pe_pkg::Q_AW'(t8pe_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/t8pe_back.sv]
// back end: sequencer that executes items against register file, memory and pc
`timescale 1ns / 1ps

module t8pe_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  t8pe_pkg::t8pe_item_t  head_item,
  input  t8pe_pkg::t8pe_qstat_t q_stat,
  output logic                  pop,
  output logic                  out_valid,
  output t8pe_pkg::t8pe_out_t   out_data
);

  t8pe_pkg::t8pe_bk_state_t state_r, state_nxt;
  t8pe_pkg::t8pe_item_t     item_r, item_nxt;
  logic [7:0]               pc_r, pc_nxt;
  logic                     halt_r, halt_nxt;
  logic [7:0]               rb_r, rb_nxt;
  logic [7:0]               rc_r, rc_nxt;
  logic                     out_valid_r, out_valid_nxt;
  t8pe_pkg::t8pe_out_t      out_r, out_nxt;

  // storage and registered read data
  logic [7:0] rf_r   [t8pe_pkg::REG_COUNT];
  logic [7:0] dmem_r [t8pe_pkg::MEM_BYTES];
  logic [7:0] rd0_r, rd1_r, mrd_r;

  logic [t8pe_pkg::REG_AW-1:0] rd0_addr, rd1_addr, rf_waddr;
  logic [t8pe_pkg::MEM_AW-1:0] mem_raddr, mem_waddr;
  logic                        rf_we, mem_we;
  logic [7:0]                  rf_wdata, mem_wdata;

  logic [7:0]  ra, offset, eaddr, pc_seq, pc_rel, alu_res;
  logic [15:0] prod;
  logic        is_exec;

  assign pop       = (state_r == t8pe_pkg::BK_IDLE) && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // operand and address arithmetic
  assign ra      = rd0_r;
  assign offset  = {{4{item_r.c_fld[3]}}, item_r.c_fld};
  assign eaddr   = rb_r + offset;
  assign prod    = rb_r * rc_r;
  assign pc_seq  = pc_r + 8'd2;
  assign pc_rel  = pc_seq + {item_r.imm[6:0], 1'b0};
  assign is_exec = (item_r.kind == t8pe_pkg::K_ALU) || (item_r.kind == t8pe_pkg::K_LOAD) ||
                   (item_r.kind == t8pe_pkg::K_STORE) || (item_r.kind == t8pe_pkg::K_JUMP) ||
                   (item_r.kind == t8pe_pkg::K_BRANCH) || (item_r.kind == t8pe_pkg::K_NOP) ||
                   (item_r.kind == t8pe_pkg::K_HALT);

  // read port addresses: operands first, then the destination register
  assign rd0_addr  = (state_r == t8pe_pkg::BK_RD1) ? item_r.a_idx :
                     (item_r.kind == t8pe_pkg::K_RDREG) ? item_r.tgt[t8pe_pkg::REG_AW-1:0] :
                     item_r.b_idx;
  assign rd1_addr  = item_r.c_fld[t8pe_pkg::REG_AW-1:0];
  assign mem_raddr = (item_r.kind == t8pe_pkg::K_RDMEM) ? item_r.tgt[t8pe_pkg::MEM_AW-1:0]
                                                        : eaddr[t8pe_pkg::MEM_AW-1:0];

  // alu
  always_comb begin
    case (item_r.alu)
      t8pe_pkg::ALU_ADD: alu_res = rb_r + rc_r;
      t8pe_pkg::ALU_SUB: alu_res = rb_r - rc_r;
      t8pe_pkg::ALU_MUL: alu_res = prod[7:0];
      t8pe_pkg::ALU_INC: alu_res = ra + 8'd1;
      t8pe_pkg::ALU_AND: alu_res = rb_r & rc_r;
      t8pe_pkg::ALU_OR:  alu_res = rb_r | rc_r;
      t8pe_pkg::ALU_NOT: alu_res = ~rb_r;
      t8pe_pkg::ALU_XOR: alu_res = rb_r ^ rc_r;
      default:           alu_res = '0;
    endcase
  end

  // sequencer next state and outputs
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    pc_nxt        = pc_r;
    halt_nxt      = halt_r;
    rb_nxt        = rb_r;
    rc_nxt        = rc_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rf_we         = 1'b0;
    rf_waddr      = item_r.a_idx;
    rf_wdata      = alu_res;
    mem_we        = 1'b0;
    mem_waddr     = item_r.tgt[t8pe_pkg::MEM_AW-1:0];
    mem_wdata     = item_r.val;
    case (state_r)
      t8pe_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          item_nxt  = head_item;
          state_nxt = t8pe_pkg::BK_RD0;
        end
      end
      t8pe_pkg::BK_RD0: begin
        state_nxt = t8pe_pkg::BK_RD1;
      end
      t8pe_pkg::BK_RD1: begin
        rb_nxt    = rd0_r;
        rc_nxt    = rd1_r;
        state_nxt = t8pe_pkg::BK_EXEC;
      end
      t8pe_pkg::BK_EXEC: begin
        out_nxt   = '0;
        state_nxt = t8pe_pkg::BK_IDLE;
        out_valid_nxt = 1'b1;
        if (!(is_exec && halt_r)) begin
          case (item_r.kind)
            t8pe_pkg::K_ALU: begin
              rf_we                  = 1'b1;
              pc_nxt                 = pc_seq;
              out_nxt.wrote_register = 1'b1;
              out_nxt.written_index  = item_r.a_idx;
              out_nxt.written_value  = alu_res;
            end
            t8pe_pkg::K_LOAD: begin
              pc_nxt        = pc_seq;
              out_valid_nxt = 1'b0;
              state_nxt     = t8pe_pkg::BK_MEM;
            end
            t8pe_pkg::K_STORE: begin
              mem_we    = 1'b1;
              mem_waddr = eaddr[t8pe_pkg::MEM_AW-1:0];
              mem_wdata = ra;
              pc_nxt    = pc_seq;
            end
            t8pe_pkg::K_JUMP:   pc_nxt = pc_rel;
            t8pe_pkg::K_BRANCH: pc_nxt = (ra == 8'd0) ? pc_rel : pc_seq;
            t8pe_pkg::K_NOP:    pc_nxt = pc_seq;
            t8pe_pkg::K_HALT:   halt_nxt = 1'b1;
            t8pe_pkg::K_LDREG: begin
              rf_we                  = 1'b1;
              rf_waddr               = item_r.tgt[t8pe_pkg::REG_AW-1:0];
              rf_wdata               = item_r.val;
              out_nxt.wrote_register = 1'b1;
              out_nxt.written_index  = 4'(item_r.tgt[t8pe_pkg::REG_AW-1:0]);
              out_nxt.written_value  = item_r.val;
            end
            t8pe_pkg::K_LDMEM: mem_we = 1'b1;
            t8pe_pkg::K_RDMEM: begin
              out_valid_nxt = 1'b0;
              state_nxt     = t8pe_pkg::BK_MEM;
            end
            t8pe_pkg::K_RDREG: out_nxt.read_data = rb_r;
            default: ;
          endcase
        end
        out_nxt.next_pc = pc_nxt;
        out_nxt.halted  = halt_nxt;
      end
      t8pe_pkg::BK_MEM: begin
        out_nxt         = '0;
        out_nxt.next_pc = pc_r;
        out_nxt.halted  = halt_r;
        if (item_r.kind == t8pe_pkg::K_LOAD) begin
          rf_we                  = 1'b1;
          rf_wdata               = mrd_r;
          out_nxt.wrote_register = 1'b1;
          out_nxt.written_index  = item_r.a_idx;
          out_nxt.written_value  = mrd_r;
        end else begin
          out_nxt.read_data = mrd_r;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = t8pe_pkg::BK_IDLE;
      end
      default: state_nxt = t8pe_pkg::BK_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= t8pe_pkg::BK_IDLE;
      pc_r        <= '0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      halt_r      <= halt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    rb_r   <= rb_nxt;
    rc_r   <= rc_nxt;
    out_r  <= out_nxt;
  end

  // register file, two registered read ports
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_r[rf_waddr] <= rf_wdata;
    end
    rd0_r <= rf_r[rd0_addr];
    rd1_r <= rf_r[rd1_addr];
  end

  // data memory, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      dmem_r[mem_waddr] <= mem_wdata;
    end
    mrd_r <= dmem_r[mem_raddr];
  end

endmodule

[rtl/toy_8bit_processor_execute_top.sv]
// top level of the toy 8-bit processor execute block
`timescale 1ns / 1ps

// Executes one command per transaction: run a 16-bit instruction, load or read a
// register, load or read a data memory byte. A transaction is taken at a clock edge
// with start high and busy low; it goes through a two-entry queue to a sequencer
// that reads the register file through registered ports. The sequencer takes a
// transaction from the queue, reads the register file in the RD0 and RD1 states and
// executes; load instructions and memory byte reads add one registered data memory
// read. It takes the next transaction from the queue only once it is back in idle,
// while the queue can still accept new transactions. busy is high only while the
// queue is full. Every result appears for exactly one cycle with out_valid high and
// must be taken then: the receiver cannot hold it off. Results come in order, one
// per transaction.

module toy_8bit_processor_execute_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  t8pe_pkg::t8pe_in_t  in_data,
  output logic                out_valid,
  output t8pe_pkg::t8pe_out_t out_data
);

  t8pe_pkg::t8pe_item_t  push_item;
  t8pe_pkg::t8pe_item_t  head_item;
  t8pe_pkg::t8pe_qstat_t q_stat;
  logic                  push;
  logic                  pop;

  // classify incoming transactions
  t8pe_front u_front (
    .start   (start),
    .in_data (in_data),
    .q_stat  (q_stat),
    .busy    (busy),
    .push    (push),
    .item    (push_item)
  );

  // decoupling queue
  t8pe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  // execute sequencer
  t8pe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_item (head_item),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // an accepted transaction is in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !q_stat.empty)
    else $error("accepted transaction missing from queue");

  // the sequencer never strobes two results back to back
  a_no_double_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // write fields are zero when no register was written
  a_clean_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.wrote_register) |->
      (out_data.written_index == 4'd0 && out_data.written_value == 8'd0))
    else $error("write fields set without a register write");
`endif

endmodule

[bench/toy_8bit_processor_execute_checker.sv]
// checker for the toy 8-bit processor execute block: shadow machine and result compare
`timescale 1ns / 1ps

module toy_8bit_processor_execute_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  t8pe_pkg::t8pe_in_t  in_data,
  input  logic                out_valid,
  input  t8pe_pkg::t8pe_out_t out_data,
  output int                  fail_count,
  output int                  outstanding
);

  // shadow copy of the machine state
  logic [7:0] reg_shadow [t8pe_pkg::REG_COUNT];
  logic [7:0] mem_shadow [t8pe_pkg::MEM_BYTES];
  logic [7:0] pc_shadow;
  logic       halt_shadow;

  // results still owed by the block, oldest first
  t8pe_pkg::t8pe_out_t owed_results [$];
  t8pe_pkg::t8pe_out_t want_r;
  t8pe_pkg::t8pe_out_t next_r;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // runs one command on the shadow state and returns its result
  task automatic run_command(input t8pe_pkg::t8pe_in_t cmd_in,
                             output t8pe_pkg::t8pe_out_t res_out);
    logic [3:0] op, ra, rb, rc;
    logic [7:0] alu_res, nxt, addr;
    logic       wr;
    res_out = '0;
    op = cmd_in.instr_word[15:12];
    ra = cmd_in.instr_word[11:8];
    rb = cmd_in.instr_word[7:4];
    rc = cmd_in.instr_word[3:0];
    if (cmd_in.cmd == t8pe_pkg::CMD_EXECUTE && !halt_shadow) begin
      nxt     = pc_shadow + 8'd2;
      wr      = 1'b1;
      alu_res = '0;
      // base register plus sign-extended 4-bit offset
      addr    = reg_shadow[rb] + {{4{rc[3]}}, rc};
      case (op)
        t8pe_pkg::OP_ADD: alu_res = reg_shadow[rb] + reg_shadow[rc];
        t8pe_pkg::OP_SUB: alu_res = reg_shadow[rb] - reg_shadow[rc];
        t8pe_pkg::OP_MUL: alu_res = reg_shadow[rb] * reg_shadow[rc];
        t8pe_pkg::OP_INC: alu_res = reg_shadow[ra] + 8'd1;
        t8pe_pkg::OP_AND: alu_res = reg_shadow[rb] & reg_shadow[rc];
        t8pe_pkg::OP_OR:  alu_res = reg_shadow[rb] | reg_shadow[rc];
        t8pe_pkg::OP_NOT: alu_res = ~reg_shadow[rb];
        t8pe_pkg::OP_XOR: alu_res = reg_shadow[rb] ^ reg_shadow[rc];
        t8pe_pkg::OP_LOAD: alu_res = mem_shadow[int'(addr) % t8pe_pkg::MEM_BYTES];
        t8pe_pkg::OP_STORE: begin
          wr = 1'b0;
          mem_shadow[int'(addr) % t8pe_pkg::MEM_BYTES] = reg_shadow[ra];
        end
        // relative jump, word offset in bits 10:4
        t8pe_pkg::OP_JUMP: begin
          wr  = 1'b0;
          nxt = nxt + {cmd_in.instr_word[10:4], 1'b0};
        end
        t8pe_pkg::OP_BRANCH: begin
          wr = 1'b0;
          if (reg_shadow[ra] == 8'd0) nxt = nxt + {cmd_in.instr_word[6:0], 1'b0};
        end
        t8pe_pkg::OP_HALT: begin
          wr          = 1'b0;
          halt_shadow = 1'b1;
          nxt         = pc_shadow;
        end
        default: wr = 1'b0;
      endcase
      if (wr) begin
        reg_shadow[ra]         = alu_res;
        res_out.wrote_register = 1'b1;
        res_out.written_index  = ra;
        res_out.written_value  = alu_res;
      end
      pc_shadow = nxt;
    end else if (cmd_in.cmd == t8pe_pkg::CMD_LOAD_REG) begin
      reg_shadow[cmd_in.target_index[3:0]] = cmd_in.load_value;
      res_out.wrote_register = 1'b1;
      res_out.written_index  = cmd_in.target_index[3:0];
      res_out.written_value  = cmd_in.load_value;
    end else if (cmd_in.cmd == t8pe_pkg::CMD_LOAD_MEM) begin
      mem_shadow[int'(cmd_in.target_index) % t8pe_pkg::MEM_BYTES] = cmd_in.load_value;
    end else if (cmd_in.cmd == t8pe_pkg::CMD_READ_MEM) begin
      res_out.read_data = mem_shadow[int'(cmd_in.target_index) % t8pe_pkg::MEM_BYTES];
    end else if (cmd_in.cmd == t8pe_pkg::CMD_READ_REG) begin
      res_out.read_data = reg_shadow[cmd_in.target_index[3:0]];
    end
    res_out.next_pc = pc_shadow;
    res_out.halted  = halt_shadow;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // compare each result with the oldest owed one, then log any accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      pc_shadow   = '0;
      halt_shadow = 1'b0;
      owed_results.delete();
    end else begin
      if (out_valid) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result with no transaction pending, expected none, actual %h",
                   $time, out_data);
          fail_count++;
        end else begin
          want_r = owed_results.pop_front();
          check_field("next_pc", want_r.next_pc, out_data.next_pc);
          check_field("halted", want_r.halted, out_data.halted);
          check_field("wrote_register", want_r.wrote_register, out_data.wrote_register);
          check_field("written_index", want_r.written_index, out_data.written_index);
          check_field("written_value", want_r.written_value, out_data.written_value);
          check_field("read_data", want_r.read_data, out_data.read_data);
        end
      end
      if (start && !busy) begin
        run_command(in_data, next_r);
        owed_results.push_back(next_r);
      end
    end
    outstanding = owed_results.size();
  end

endmodule

[bench/toy_8bit_processor_execute_top_tb.sv]
// testbench top for the toy 8-bit processor execute block: stimulus and verdict
`timescale 1ns / 1ps

module toy_8bit_processor_execute_top_tb;

  localparam logic [2:0] CMD_TOP = '1;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  t8pe_pkg::t8pe_in_t  in_data   = '0;
  logic                busy;
  logic                out_valid;
  t8pe_pkg::t8pe_out_t out_data;
  int                  fail_count;
  int                  outstanding;
  bit                  idle_ok;

  always #5 clk = ~clk;

  toy_8bit_processor_execute_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  toy_8bit_processor_execute_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  function automatic t8pe_pkg::t8pe_in_t make_cmd(input logic [2:0] cmd,
                                                  input logic [15:0] word,
                                                  input logic [7:0] tgt,
                                                  input logic [7:0] val);
    t8pe_pkg::t8pe_in_t c;
    c.cmd          = cmd;
    c.instr_word   = word;
    c.target_index = tgt;
    c.load_value   = val;
    return c;
  endfunction

  // byte values leaning toward zero and all-ones so branches get taken
  function automatic logic [7:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  // random command, mostly instructions; halt only when allowed
  function automatic t8pe_pkg::t8pe_in_t random_cmd(input bit with_halt);
    t8pe_pkg::t8pe_in_t c;
    int                 sel;
    c.instr_word   = 16'($urandom);
    c.target_index = 8'($urandom);
    c.load_value   = pick_byte();
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      c.cmd = t8pe_pkg::CMD_EXECUTE;
      c.instr_word[15:12] = with_halt ? 4'($urandom) :
                            4'($urandom_range(int'(t8pe_pkg::OP_ADD),
                                              int'(t8pe_pkg::OP_HALT) - 1));
    end else if (sel < 70) c.cmd = t8pe_pkg::CMD_LOAD_REG;
    else if (sel < 78)     c.cmd = t8pe_pkg::CMD_LOAD_MEM;
    else if (sel < 86)     c.cmd = t8pe_pkg::CMD_READ_MEM;
    else if (sel < 96)     c.cmd = t8pe_pkg::CMD_READ_REG;
    else c.cmd = 3'($urandom_range(int'(t8pe_pkg::CMD_READ_REG) + 1, int'(CMD_TOP)));
    return c;
  endfunction

  // present one transaction, with an optional idle burst first, and wait for acceptance
  task automatic send_txn(input t8pe_pkg::t8pe_in_t c);
    bit took;
    if (idle_ok && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= c;
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
  endtask

  // stimulus and verdict
  initial begin
    idle_ok = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every register and memory byte so later reads see written data
    for (int i = 0; i < t8pe_pkg::REG_COUNT; i++)
      send_txn(make_cmd(t8pe_pkg::CMD_LOAD_REG, 16'($urandom), {4'($urandom), 4'(i)},
                        pick_byte()));
    for (int i = 0; i < t8pe_pkg::MEM_BYTES; i++)
      send_txn(make_cmd(t8pe_pkg::CMD_LOAD_MEM, 16'($urandom), 8'(i), pick_byte()));

    // directed: operand extremes, every opcode but halt, odd commands
    send_txn(make_cmd(t8pe_pkg::CMD_LOAD_REG, 16'h0000, 8'hf1, 8'hff));
    send_txn(make_cmd(t8pe_pkg::CMD_LOAD_REG, 16'hffff, 8'h02, 8'hff));
    send_txn(make_cmd(t8pe_pkg::CMD_LOAD_REG, 16'h0000, 8'h03, 8'h00));
    send_txn(make_cmd(t8pe_pkg::CMD_LOAD_REG, 16'h0000, 8'h04, 8'h80));
    send_txn(make_cmd(t8pe_pkg::CMD_LOAD_REG, 16'h0000, 8'h05, 8'h7f));
    send_txn(make_cmd(t8pe_pkg::CMD_EXECUTE, {t8pe_pkg::OP_ADD, 12'h612}, 8'h00, 8'h00));
    send_txn(make_cmd(t8pe_pkg::CMD_EXECUTE, {t8pe_pkg::OP_SUB, 12'h731}, 8'h00, 8'h00));
    send_txn(make_cmd(t8pe_pkg::CMD_EXECUTE, {t8pe_pkg::OP_MUL, 12'h812}, 8'h00, 8'h00));
    send_txn(make_cmd(t8pe_pkg::CMD_EXECUTE, {t8pe_pkg::OP_INC, 12'h1ff}, 8'h00, 8'h00));
    send_txn(make_cmd(t8pe_pkg::CMD_EXECUTE, {t8pe_pkg::OP_AND, 12'h945}, 8'h00, 8'h00));
    send_txn(make_cmd(t8pe_pkg::CMD_EXECUTE, {t8pe_pkg::OP_OR,  12'ha35}, 8'h00, 8'h00));
    send_txn(make_cmd(t8pe_pkg::CMD_EXECUTE, {t8pe_pkg::OP_NOT, 12'hb30}, 8'h00, 8'h00));
    send_txn(make_cmd(t8pe_pkg::CMD_EXECUTE, {t8pe_pkg::OP_XOR, 12'hc24}, 8'h00, 8'h00));
    // memory offsets at both ends of the signed range, store then load back
    send_txn(make_cmd(t8pe_pkg::CMD_EXECUTE, {t8pe_pkg::OP_LOAD,  12'hd48}, 8'h00, 8'h00));
    send_txn(make_cmd(t8pe_pkg::CMD_EXECUTE, {t8pe_pkg::OP_LOAD,  12'hd57}, 8'h00, 8'h00));
    send_txn(make_cmd(t8pe_pkg::CMD_EXECUTE, {t8pe_pkg::OP_STORE, 12'he48}, 8'h00, 8'h00));
    send_txn(make_cmd(t8pe_pkg::CMD_EXECUTE, {t8pe_pkg::OP_LOAD,  12'hf48}, 8'h00, 8'h00));
    // jumps at the largest and smallest offsets, branch taken and not
    send_txn(make_cmd(t8pe_pkg::CMD_EXECUTE, {t8pe_pkg::OP_JUMP,   12'h7f0}, 8'h00, 8'h00));
    send_txn(make_cmd(t8pe_pkg::CMD_EXECUTE, {t8pe_pkg::OP_JUMP,   12'h800}, 8'h00, 8'h00));
    send_txn(make_cmd(t8pe_pkg::CMD_EXECUTE, {t8pe_pkg::OP_BRANCH, 12'h380}, 8'h00, 8'h00));
    send_txn(make_cmd(t8pe_pkg::CMD_EXECUTE, {t8pe_pkg::OP_BRANCH, 12'h27f}, 8'h00, 8'h00));
    // no-op opcodes, unknown commands, reads at the address extremes
    send_txn(make_cmd(t8pe_pkg::CMD_EXECUTE, {4'(t8pe_pkg::OP_BRANCH + 1), 12'hfff},
                      8'hff, 8'hff));
    send_txn(make_cmd(t8pe_pkg::CMD_EXECUTE, {4'(t8pe_pkg::OP_HALT - 1), 12'h000},
                      8'h00, 8'h00));
    send_txn(make_cmd(CMD_TOP, 16'hffff, 8'hff, 8'hff));
    send_txn(make_cmd(t8pe_pkg::CMD_READ_MEM, 16'h0000, 8'hff, 8'h00));
    send_txn(make_cmd(t8pe_pkg::CMD_READ_REG, 16'hffff, 8'hf0, 8'hff));

    // random instruction stream, idling switched per block of transactions
    for (int i = 0; i < 1200; i++) begin
      if (i % 100 == 0) idle_ok = (i < 1100) && ($urandom_range(0, 2) != 0);
      send_txn(random_cmd(1'b0));
    end

    // halt, then executes that must be ignored while loads and reads still work
    send_txn(make_cmd(t8pe_pkg::CMD_EXECUTE, {t8pe_pkg::OP_HALT, 12'($urandom)},
                      8'($urandom), 8'($urandom)));
    for (int i = 0; i < 60; i++) send_txn(random_cmd(1'b1));
    start <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("toy_8bit_processor_execute_top_tb OK");
    end else begin
      $display("toy_8bit_processor_execute_top_tb NOT OK");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #5000000;
    $display("toy_8bit_processor_execute_top_tb NOT OK");
    $finish;
  end

endmodule

[toy_8bit_processor_execute_top.f]
rtl/t8pe_pkg.sv
rtl/t8pe_front.sv
rtl/t8pe_queue.sv
rtl/t8pe_back.sv
rtl/toy_8bit_processor_execute_top.sv
bench/toy_8bit_processor_execute_checker.sv
bench/toy_8bit_processor_execute_top_tb.sv
